// ----- hw/rtl/bcd_pkg.sv -----
// ----------------------------------------------------------------------------
// bcd_pkg
// types, format codes and arithmetic helpers for the bc1/bc2/bc3 block decoder
// ----------------------------------------------------------------------------
package bcd_pkg;

    localparam logic [1:0] FMT_BC1     = 2'd0;
    localparam logic [1:0] FMT_BC2     = 2'd1;
    localparam logic [1:0] FMT_BC3     = 2'd2;
    localparam logic [1:0] FMT_BC1_ALT = 2'd3;

    localparam logic [1:0] CI_TRANSPARENT = 2'd3;

    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;
    localparam int DIV5_MUL   = 3277;
    localparam int DIV5_SHIFT = 14;
    localparam int DIV7_MUL   = 2341;
    localparam int DIV7_SHIFT = 14;

    typedef logic [1:0] t_format;

    // channel order: 0 blue, 1 green, 2 red
    typedef logic [2:0][7:0] t_rgb;

    typedef struct packed {
        logic [15:0] color_endpoint0;
        logic [15:0] color_endpoint1;
        logic [31:0] color_indices;
        logic [63:0] alpha_bits;
    } t_in_item;

    typedef struct packed {
        logic [3:0] pixel_index;
        logic [7:0] pixel_blue;
        logic [7:0] pixel_green;
        logic [7:0] pixel_red;
        logic [7:0] pixel_alpha;
        logic       last_pixel;
    } t_out_item;

    function automatic t_rgb expand565(input logic [15:0] c);
        t_rgb v;
        v[2] = {c[15:11], c[15:13]};
        v[1] = {c[10:5], c[10:9]};
        v[0] = {c[4:0], c[4:2]};
        return v;
    endfunction

    // x <= 765
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [20:0] p;
        p = 21'(x) * 21'(DIV3_MUL);
        return p[DIV3_SHIFT +: 8];
    endfunction

    // x <= 1275
    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [22:0] p;
        p = 23'(x) * 23'(DIV5_MUL);
        return p[DIV5_SHIFT +: 8];
    endfunction

    // x <= 1785
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [22:0] p;
        p = 23'(x) * 23'(DIV7_MUL);
        return p[DIV7_SHIFT +: 8];
    endfunction

endpackage

// ----- hw/rtl/bcd_if.sv -----
// ----------------------------------------------------------------------------
// bcd channel interfaces
// valid/ready channels for blocks in, pixels out and the format register
// ----------------------------------------------------------------------------
interface bcd_in_if;
    logic              valid;
    logic              ready;
    bcd_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bcd_out_if;
    logic               valid;
    logic               ready;
    bcd_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bcd_cfg_if;
    logic             valid;
    logic             ready;
    bcd_pkg::t_format data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/bc1_bc2_bc3_block_decoder_core.sv -----
// ----------------------------------------------------------------------------
// bc1_bc2_bc3_block_decoder_core
// decodes one bc1/bc2/bc3 4x4 block into sixteen bgra pixels in raster order
// ----------------------------------------------------------------------------
// A block is taken on i_in and comes out as sixteen pixel transfers on o_out,
// one per cycle while o_out is ready, pixel 0 first, last_pixel set on pixel
// 15. The single output channel sets the rate. Blocks pass an input register,
// an endpoint expand and weighted-sum stage, a palette stage (divides by 3, 5
// and 7 as reciprocal multiplies), a pixel serializer holding the palette and
// an output register, and the next block is taken while the previous one is
// still being emitted. The format register (0 bc1, 1 bc2, 2 bc3, 3 as bc1)
// is always ready and is sampled with each block as it enters.
module bc1_bc2_bc3_block_decoder_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bcd_in_if.sink          i_in,
    bcd_out_if.source       o_out,
    bcd_cfg_if.sink         i_cfg
);

    // format register
    bcd_pkg::t_format r_format;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= bcd_pkg::FMT_BC1;
        end else if (i_cfg.valid) begin
            r_format <= i_cfg.data;
        end
    end

    // stage control
    logic r_a_valid, r_b_valid, r_c_valid, r_d_valid, r_o_valid;
    logic [3:0] r_d_cnt;
    logic o_free, d_fire, d_done, d_free, c_free, b_free, a_free;

    assign o_free = !r_o_valid || o_out.ready;
    assign d_fire = r_d_valid && o_free;
    assign d_done = d_fire && (r_d_cnt == 4'd15);
    assign d_free = !r_d_valid || d_done;
    assign c_free = !r_c_valid || d_free;
    assign b_free = !r_b_valid || c_free;
    assign a_free = !r_a_valid || b_free;

    assign i_in.ready = a_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_d_cnt   <= 4'd0;
        end else begin
            if (a_free) begin
                r_a_valid <= i_in.valid;
            end
            if (b_free) begin
                r_b_valid <= r_a_valid;
            end
            if (c_free) begin
                r_c_valid <= r_b_valid;
            end
            if (d_free) begin
                r_d_valid <= r_c_valid;
            end
            if (o_free) begin
                r_o_valid <= r_d_valid;
            end
            if (d_free) begin
                r_d_cnt <= 4'd0;
            end else if (d_fire) begin
                r_d_cnt <= r_d_cnt + 4'd1;
            end
        end
    end

    // stage a: input register
    bcd_pkg::t_in_item r_a_item;
    bcd_pkg::t_format  r_a_mode;

    always_ff @(posedge i_clk) begin
        if (a_free) begin
            r_a_item <= i_in.data;
            r_a_mode <= r_format;
        end
    end

    // stage b: expanded endpoints and weighted sums
    bcd_pkg::t_rgb    n_b_c0, n_b_c1;
    logic [2:0][9:0]  n_b_s2, n_b_s3;
    logic [2:0][8:0]  n_b_s01;
    logic             n_b_four, n_b_a7;
    logic [5:0][10:0] n_b_asum;
    logic [7:0]       a0, a1;
    logic             a_bc1;

    assign a0    = r_a_item.alpha_bits[7:0];
    assign a1    = r_a_item.alpha_bits[15:8];
    assign a_bc1 = (r_a_mode == bcd_pkg::FMT_BC1) || (r_a_mode == bcd_pkg::FMT_BC1_ALT);

    always_comb begin
        n_b_c0   = bcd_pkg::expand565(r_a_item.color_endpoint0);
        n_b_c1   = bcd_pkg::expand565(r_a_item.color_endpoint1);
        n_b_four = !a_bc1 || (r_a_item.color_endpoint0 > r_a_item.color_endpoint1);
        n_b_a7   = a0 > a1;
        for (int ch = 0; ch < 3; ch++) begin
            n_b_s2[ch]  = {1'b0, n_b_c0[ch], 1'b0} + 10'(n_b_c1[ch]);
            n_b_s3[ch]  = 10'(n_b_c0[ch]) + {1'b0, n_b_c1[ch], 1'b0};
            n_b_s01[ch] = 9'(n_b_c0[ch]) + 9'(n_b_c1[ch]);
        end
        for (int k = 0; k < 6; k++) begin
            if (n_b_a7) begin
                n_b_asum[k] = 11'(6 - k) * 11'(a0) + 11'(k + 1) * 11'(a1);
            end else if (k < 4) begin
                n_b_asum[k] = 11'(4 - k) * 11'(a0) + 11'(k + 1) * 11'(a1);
            end else begin
                n_b_asum[k] = 11'd0;
            end
        end
    end

    bcd_pkg::t_rgb    r_b_c0, r_b_c1;
    logic [2:0][9:0]  r_b_s2, r_b_s3;
    logic [2:0][8:0]  r_b_s01;
    logic             r_b_four, r_b_a7;
    logic [5:0][10:0] r_b_asum;
    logic [31:0]      r_b_idx;
    logic [63:0]      r_b_abits;
    bcd_pkg::t_format r_b_mode;

    always_ff @(posedge i_clk) begin
        if (b_free) begin
            r_b_c0    <= n_b_c0;
            r_b_c1    <= n_b_c1;
            r_b_s2    <= n_b_s2;
            r_b_s3    <= n_b_s3;
            r_b_s01   <= n_b_s01;
            r_b_four  <= n_b_four;
            r_b_a7    <= n_b_a7;
            r_b_asum  <= n_b_asum;
            r_b_idx   <= r_a_item.color_indices;
            r_b_abits <= r_a_item.alpha_bits;
            r_b_mode  <= r_a_mode;
        end
    end

    // stage c: palettes
    bcd_pkg::t_rgb [3:0] n_c_pal;
    logic [7:0]          n_c_pa3;
    logic [7:0][7:0]     n_c_apal;

    always_comb begin
        n_c_pal[0] = r_b_c0;
        n_c_pal[1] = r_b_c1;
        for (int ch = 0; ch < 3; ch++) begin
            if (r_b_four) begin
                n_c_pal[2][ch] = bcd_pkg::div3(r_b_s2[ch]);
                n_c_pal[3][ch] = bcd_pkg::div3(r_b_s3[ch]);
            end else begin
                n_c_pal[2][ch] = r_b_s01[ch][8:1];
                n_c_pal[3][ch] = 8'd0;
            end
        end
        n_c_pa3     = r_b_four ? 8'hFF : 8'h00;
        n_c_apal[0] = r_b_abits[7:0];
        n_c_apal[1] = r_b_abits[15:8];
        for (int k = 0; k < 6; k++) begin
            if (r_b_a7) begin
                n_c_apal[k + 2] = bcd_pkg::div7(r_b_asum[k]);
            end else if (k < 4) begin
                n_c_apal[k + 2] = bcd_pkg::div5(r_b_asum[k]);
            end else if (k == 4) begin
                n_c_apal[k + 2] = 8'h00;
            end else begin
                n_c_apal[k + 2] = 8'hFF;
            end
        end
    end

    bcd_pkg::t_rgb [3:0] r_c_pal;
    logic [7:0]          r_c_pa3;
    logic [7:0][7:0]     r_c_apal;
    logic [31:0]         r_c_idx;
    logic [63:0]         r_c_abits;
    bcd_pkg::t_format    r_c_mode;

    always_ff @(posedge i_clk) begin
        if (c_free) begin
            r_c_pal   <= n_c_pal;
            r_c_pa3   <= n_c_pa3;
            r_c_apal  <= n_c_apal;
            r_c_idx   <= r_b_idx;
            r_c_abits <= r_b_abits;
            r_c_mode  <= r_b_mode;
        end
    end

    // stage d: pixel serializer
    bcd_pkg::t_rgb [3:0] r_d_pal;
    logic [7:0]          r_d_pa3;
    logic [7:0][7:0]     r_d_apal;
    logic [31:0]         r_d_idx;
    logic [63:0]         r_d_abits;
    bcd_pkg::t_format    r_d_mode;

    always_ff @(posedge i_clk) begin
        if (d_free) begin
            r_d_pal   <= r_c_pal;
            r_d_pa3   <= r_c_pa3;
            r_d_apal  <= r_c_apal;
            r_d_idx   <= r_c_idx;
            r_d_abits <= r_c_abits;
            r_d_mode  <= r_c_mode;
        end
    end

    logic [31:0]        idx_sh;
    logic [63:0]        nib_sh, ai_sh;
    logic [5:0]         ai_base;
    logic [1:0]         ci;
    logic [3:0]         nib;
    logic [2:0]         ai;
    bcd_pkg::t_out_item n_pixel;

    always_comb begin
        idx_sh  = r_d_idx >> {r_d_cnt, 1'b0};
        nib_sh  = r_d_abits >> {r_d_cnt, 2'b00};
        ai_base = 6'd16 + 6'(r_d_cnt) * 6'd3;
        ai_sh   = r_d_abits >> ai_base;
        ci      = idx_sh[1:0];
        nib     = nib_sh[3:0];
        ai      = ai_sh[2:0];

        n_pixel.pixel_index = r_d_cnt;
        n_pixel.pixel_blue  = r_d_pal[ci][0];
        n_pixel.pixel_green = r_d_pal[ci][1];
        n_pixel.pixel_red   = r_d_pal[ci][2];
        n_pixel.last_pixel  = (r_d_cnt == 4'd15);
        case (r_d_mode)
            bcd_pkg::FMT_BC2: begin
                n_pixel.pixel_alpha = {nib, nib};
            end
            bcd_pkg::FMT_BC3: begin
                n_pixel.pixel_alpha = r_d_apal[ai];
            end
            default: begin
                n_pixel.pixel_alpha = (ci == bcd_pkg::CI_TRANSPARENT) ? r_d_pa3 : 8'hFF;
            end
        endcase
    end

    // output register
    bcd_pkg::t_out_item r_o_item;

    always_ff @(posedge i_clk) begin
        if (o_free) begin
            r_o_item <= n_pixel;
        end
    end

    assign o_out.valid = r_o_valid;
    assign o_out.data  = r_o_item;

`ifndef ASSERT_OFF
    a_last_is_fifteen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_item.last_pixel |-> r_o_item.pixel_index == 4'd15)
        else $error("last_pixel on a pixel other than fifteen");

    a_cnt_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_d_valid |-> r_d_cnt == 4'd0)
        else $error("serializer count moved without a block");

    a_cnt_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_valid && !o_free |=> $stable(r_d_cnt))
        else $error("serializer count moved during output stall");

    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_a_valid)
        else $error("accepted block not captured");

    a_pixel_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d_fire && !d_done |=> r_d_valid && r_d_cnt == $past(r_d_cnt) + 4'd1)
        else $error("pixel sequence broken");
`endif

endmodule
